// ===== rtl/alr_pkg.sv =====
package alr_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int SLOPE_FRAC_BITS = 16;
   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int CIN_W     = 21;
   localparam int DIFF_W    = CIN_W + 1;
   localparam int COL_W     = 14;
   localparam int CROSS_W   = COL_W + SLOPE_FRAC_BITS;
   localparam int SLOPE_W   = SLOPE_FRAC_BITS + 2;
   localparam int QUOT_W    = SLOPE_FRAC_BITS + 1;
   localparam int GAP_W     = COORD_FRAC_BITS + 1;
   localparam int PROD_W    = SLOPE_W + GAP_W;
   localparam int YW_W      = CIN_W + SLOPE_FRAC_BITS + 1;
   localparam int YEND_W    = YW_W - COORD_FRAC_BITS;
   localparam int M1_W      = SLOPE_FRAC_BITS + 1 + GAP_W;
   localparam int M2_W      = M1_W + 8;

   localparam int DIM_REG_W   = 13;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 120;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_USER_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd768;

   localparam logic CMD_START = 1'b0;

   typedef struct packed {
      logic                    is_start;
      logic signed [CIN_W-1:0] start_x;
      logic signed [CIN_W-1:0] start_y;
      logic signed [CIN_W-1:0] end_x;
      logic signed [CIN_W-1:0] end_y;
      logic [7:0]              opacity;
      logic [23:0]             line_color;
   } alr_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORDER,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SLOPE,
      ST_EP_MUL,
      ST_EP_Y,
      ST_COV1,
      ST_COV2,
      ST_EMIT0,
      ST_EMIT1
   } back_state_type;

endpackage

// ===== rtl/alr_front.sv =====
module alr_front
   import alr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  q_valid,
   output alr_item_type          q_item,
   input  logic                  q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   alr_item_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]             count_ff, count_in;
   alr_item_type               item;
   logic                       push;

   always_comb begin
      item.is_start   = (req_tuser == CMD_START);
      item.start_x    = req_tdata[CIN_W-1:0];
      item.start_y    = req_tdata[2*CIN_W-1:CIN_W];
      item.end_x      = req_tdata[3*CIN_W-1:2*CIN_W];
      item.end_y      = req_tdata[4*CIN_W-1:3*CIN_W];
      item.opacity    = req_tdata[4*CIN_W+7:4*CIN_W];
      item.line_color = req_tdata[4*CIN_W+31:4*CIN_W+8];
   end

   assign req_tready = (count_ff < (PTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop && q_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== rtl/alr_div.sv =====
module alr_div
   import alr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIFF_W-1:0] num,
   input  logic [DIFF_W-1:0] den,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   localparam int CNT_W = $clog2(QUOT_W);

   logic [DIFF_W:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              ge;
   logic [DIFF_W:0]   rem_sub;

   assign ge      = (rem_ff >= {1'b0, den});
   assign rem_sub = ge ? rem_ff - {1'b0, den} : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         quot_in = '0;
         cnt_in  = CNT_W'(QUOT_W-1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         rem_in  = {rem_sub[DIFF_W-1:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/alr_back.sv =====
module alr_back
   import alr_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DIM_REG_W-1:0]  image_width,
   input  logic [DIM_REG_W-1:0]  image_height,
   input  logic                  q_valid,
   input  alr_item_type          q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int S     = SLOPE_FRAC_BITS;
   localparam int C     = COORD_FRAC_BITS;
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = ((DIM_W > COL_W) ? DIM_W : COL_W) + 1;
   localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
   localparam logic [DIFF_W-1:0] HALF_D   = DIFF_W'(1) << (C - 1);
   localparam logic [GAP_W-1:0]  HALF_G   = GAP_W'(1) << (C - 1);
   localparam logic [GAP_W-1:0]  ONE_G    = GAP_W'(1) << C;
   localparam logic [S:0]        ONE_F    = (S+1)'(1) << S;
   localparam logic [SLOPE_W-1:0] ONE_SL  = SLOPE_W'(1) << S;

   back_state_type state_ff, state_in;

   logic                     steep_ff, steep_in;
   logic signed [CIN_W-1:0]  x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [DIFF_W-1:0]        dx_ff, dx_in, dyabs_ff, dyabs_in;
   logic                     dyneg_ff, dyneg_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic signed [COL_W-1:0]  cur_ff, cur_in, end_ff, end_in;
   logic                     active_ff, active_in;
   logic [CROSS_W-1:0]       cross_ff, cross_in;
   logic [7:0]               op_ff, op_in;
   logic [23:0]              color_ff, color_in;
   logic                     is_start_ff, is_start_in;
   logic                     ep_ff, ep_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [COL_W-1:0]         major_ff, major_in, minor_ff, minor_in;
   logic [GAP_W-1:0]         xgap_ff, xgap_in;
   logic [S-1:0]             f_ff, f_in;
   logic                     done_ff, done_in;
   logic [M1_W-1:0]          m1h_ff, m1h_in, m1l_ff, m1l_in;
   logic [7:0]               covh_ff, covh_in, covl_ff, covl_in;
   logic                     rvalid_ff, rvalid_in;
   logic [RSP_DATA_W-1:0]    rdata_ff, rdata_in;
   logic [RSP_USER_W-1:0]    ruser_ff, ruser_in;
   logic                     rlast_ff, rlast_in;

   logic                     div_start, div_done;
   logic [QUOT_W-1:0]        div_quot;

   logic signed [DIFF_W-1:0] rdx, rdy, odx, ody;
   logic [DIFF_W-1:0]        adx, ady;
   logic signed [CIN_W-1:0]  ox0, oy0, ox1, oy1;
   logic signed [DIFF_W-1:0] sum0, sum1, esum;
   logic signed [CIN_W-1:0]  ey;
   logic [C-1:0]             fr;
   logic signed [GAP_W-1:0]  delta;
   logic signed [YW_W-1:0]   yw;
   logic [YEND_W-1:0]        yend;
   logic signed [COL_W-1:0]  cur_next;
   logic [M2_W-1:0]          m2h, m2l;
   logic [COL_W-1:0]         em_minor, pxw, pyw;
   logic [CMP_W-1:0]         wc, hc, pxc, pyc;
   logic                     in_image, out_free;

   alr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (dyabs_ff),
      .den   (dx_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign out_free  = !rvalid_ff || rsp_tready;
   assign div_start = (state_ff == ST_DIV_START);

   always_comb begin
      rdx = DIFF_W'(q_item.end_x) - DIFF_W'(q_item.start_x);
      rdy = DIFF_W'(q_item.end_y) - DIFF_W'(q_item.start_y);
      adx = rdx[DIFF_W-1] ? DIFF_W'(-rdx) : DIFF_W'(rdx);
      ady = rdy[DIFF_W-1] ? DIFF_W'(-rdy) : DIFF_W'(rdy);
      if (x0_ff > x1_ff) begin
         ox0 = x1_ff; oy0 = y1_ff; ox1 = x0_ff; oy1 = y0_ff;
      end else begin
         ox0 = x0_ff; oy0 = y0_ff; ox1 = x1_ff; oy1 = y1_ff;
      end
      odx  = DIFF_W'(ox1) - DIFF_W'(ox0);
      ody  = DIFF_W'(oy1) - DIFF_W'(oy0);
      sum0 = DIFF_W'(x0_ff) + $signed(HALF_D);
      sum1 = DIFF_W'(x1_ff) + $signed(HALF_D);
      esum = ep_ff ? sum1 : sum0;
      ey   = ep_ff ? y1_ff : y0_ff;
      fr   = esum[C-1:0];
      delta = $signed(HALF_G - {1'b0, fr});
      yw   = ($signed(YW_W'(ey)) <<< S) + YW_W'(prod_ff);
      yend = yw[YW_W-1:C];
      cur_next = cur_ff + 1'b1;
      m2h  = m1h_ff * M2_W'(op_ff);
      m2l  = m1l_ff * M2_W'(op_ff);
   end

   always_comb begin
      em_minor = (state_ff == ST_EMIT1) ? minor_ff + 1'b1 : minor_ff;
      pxw = steep_ff ? em_minor : major_ff;
      pyw = steep_ff ? major_ff : em_minor;
      wc  = (CMP_W'(image_width) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(image_width);
      hc  = (CMP_W'(image_height) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(image_height);
      pxc = CMP_W'(pxw);
      pyc = CMP_W'(pyw);
      in_image = !pxw[COL_W-1] && !pyw[COL_W-1] && (pxc < wc) && (pyc < hc);
   end

   always_comb begin
      state_in    = state_ff;
      steep_in    = steep_ff;
      x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff; y1_in = y1_ff;
      dx_in       = dx_ff;
      dyabs_in    = dyabs_ff;
      dyneg_in    = dyneg_ff;
      slope_in    = slope_ff;
      cur_in      = cur_ff;
      end_in      = end_ff;
      active_in   = active_ff;
      cross_in    = cross_ff;
      op_in       = op_ff;
      color_in    = color_ff;
      is_start_in = is_start_ff;
      ep_in       = ep_ff;
      prod_in     = prod_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      xgap_in     = xgap_ff;
      f_in        = f_ff;
      done_in     = done_ff;
      m1h_in      = m1h_ff;
      m1l_in      = m1l_ff;
      covh_in     = covh_ff;
      covl_in     = covl_ff;
      rvalid_in   = rvalid_ff && !rsp_tready;
      rdata_in    = rdata_ff;
      ruser_in    = ruser_ff;
      rlast_in    = rlast_ff;
      q_pop       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_start) begin
                  steep_in    = (ady > adx);
                  op_in       = q_item.opacity;
                  color_in    = q_item.line_color;
                  is_start_in = 1'b1;
                  ep_in       = 1'b0;
                  if (ady > adx) begin
                     x0_in = q_item.start_y; y0_in = q_item.start_x;
                     x1_in = q_item.end_y;   y1_in = q_item.end_x;
                  end else begin
                     x0_in = q_item.start_x; y0_in = q_item.start_y;
                     x1_in = q_item.end_x;   y1_in = q_item.end_y;
                  end
                  state_in = ST_ORDER;
               end else if (active_ff) begin
                  is_start_in = 1'b0;
                  major_in    = cur_ff;
                  minor_in    = cross_ff[S+COL_W-1:S];
                  f_in        = cross_ff[S-1:0];
                  xgap_in     = ONE_G;
                  cross_in    = cross_ff + CROSS_W'(slope_ff);
                  cur_in      = cur_next;
                  active_in   = (cur_next < end_ff);
                  done_in     = !(cur_next < end_ff);
                  state_in    = ST_COV1;
               end
            end
         end
         ST_ORDER: begin
            x0_in = ox0; y0_in = oy0; x1_in = ox1; y1_in = oy1;
            dx_in    = odx;
            dyabs_in = ody[DIFF_W-1] ? DIFF_W'(-ody) : DIFF_W'(ody);
            dyneg_in = ody[DIFF_W-1];
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            if (dx_ff == '0) begin
               slope_in = $signed(ONE_SL);
            end else if (dyneg_ff) begin
               slope_in = -$signed(SLOPE_W'(div_quot));
            end else begin
               slope_in = $signed(SLOPE_W'(div_quot));
            end
            cur_in    = sum0[C+COL_W-1:C] + 1'b1;
            end_in    = sum1[C+COL_W-1:C];
            active_in = ($signed(sum0[C+COL_W-1:C] + 1'b1) < $signed(sum1[C+COL_W-1:C]));
            done_in   = !($signed(sum0[C+COL_W-1:C] + 1'b1) < $signed(sum1[C+COL_W-1:C]));
            state_in  = ST_EP_MUL;
         end
         ST_EP_MUL: begin
            prod_in  = slope_ff * delta;
            major_in = esum[C+COL_W-1:C];
            xgap_in  = ep_ff ? {1'b0, fr} : ONE_G - {1'b0, fr};
            state_in = ST_EP_Y;
         end
         ST_EP_Y: begin
            f_in     = yend[S-1:0];
            minor_in = yend[S+COL_W-1:S];
            if (!ep_ff) begin
               cross_in = yend[CROSS_W-1:0] + CROSS_W'(slope_ff);
            end
            state_in = ST_COV1;
         end
         ST_COV1: begin
            m1h_in   = (ONE_F - {1'b0, f_ff}) * M1_W'(xgap_ff);
            m1l_in   = M1_W'(f_ff) * M1_W'(xgap_ff);
            state_in = ST_COV2;
         end
         ST_COV2: begin
            covh_in  = m2h[S+C+7:S+C];
            covl_in  = m2l[S+C+7:S+C];
            state_in = ST_EMIT0;
         end
         ST_EMIT0, ST_EMIT1: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rdata_in  = {4'b0, color_ff,
                            (state_ff == ST_EMIT1) ? covl_ff : covh_ff, pyw, pxw};
               ruser_in  = {done_ff, in_image};
               rlast_in  = (state_ff == ST_EMIT1) && (!is_start_ff || ep_ff);
               if (state_ff == ST_EMIT0) begin
                  state_in = ST_EMIT1;
               end else if (is_start_ff && !ep_ff) begin
                  ep_in    = 1'b1;
                  state_in = ST_EP_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         steep_ff  <= 1'b0;
         slope_ff  <= '0;
         cur_ff    <= '0;
         end_ff    <= '0;
         active_ff <= 1'b0;
         cross_ff  <= '0;
         op_ff     <= '0;
         color_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         steep_ff  <= steep_in;
         slope_ff  <= slope_in;
         cur_ff    <= cur_in;
         end_ff    <= end_in;
         active_ff <= active_in;
         cross_ff  <= cross_in;
         op_ff     <= op_in;
         color_ff  <= color_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      dx_ff       <= dx_in;
      dyabs_ff    <= dyabs_in;
      dyneg_ff    <= dyneg_in;
      is_start_ff <= is_start_in;
      ep_ff       <= ep_in;
      prod_ff     <= prod_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      xgap_ff     <= xgap_in;
      f_ff        <= f_in;
      done_ff     <= done_in;
      m1h_ff      <= m1h_in;
      m1l_ff      <= m1l_in;
      covh_ff     <= covh_in;
      covl_ff     <= covl_in;
      rdata_ff    <= rdata_in;
      ruser_ff    <= ruser_in;
      rlast_ff    <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
   assign rsp_tlast  = rlast_ff;

endmodule

// ===== rtl/antialiased_line_rasterizer.sv =====
// Anti-aliased line rasterizer. A start item (tuser 0) takes two 13.8 endpoints,
// opacity and color and yields four endpoint pixel writes; each step item
// (tuser 1) yields the two writes of the next interior column, and a step with
// no line in progress yields nothing. Results leave one per cycle at best. A start
// item is dequeued, ordered and launched on the bit-serial slope divider, waits
// on it, takes the slope state, then for each endpoint the arithmetic states
// EP_MUL, EP_Y, COV1 and COV2 and the writes EMIT0 and EMIT1. A step item passes
// through a dequeue state, the two registered coverage multiplies and the two
// writes. A two-entry queue takes items while the back end works. Image size
// registers may be written only while idle.
module antialiased_line_rasterizer
   import alr_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // start_x, start_y, end_x, end_y, opacity, line_color
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pixel_x, pixel_y, coverage, pixel_color
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // inside_res, done_res
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_REG_W-1:0]  csr_data
);

   logic [DIM_REG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic                 q_valid, q_pop;
   alr_item_type         q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   alr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   alr_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== rtl/alr_checker.sv =====
module alr_checker
   import alr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled transfer changed");

   a_inside_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[COL_W-1] && !rsp_tdata[2*COL_W-1])
      else $error("inside flag on negative pixel");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind antialiased_line_rasterizer alr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/antialiased_line_rasterizer_test.sv =====
module antialiased_line_rasterizer_test;
   import alr_pkg::*;

   typedef struct packed {
      bit                cmd;
      logic signed [20:0] sx;
      logic signed [20:0] sy;
      logic signed [20:0] ex;
      logic signed [20:0] ey;
      logic [7:0]         op;
      logic [23:0]        color;
   } raster_item_type;

   typedef struct packed {
      logic [13:0] px;
      logic [13:0] py;
      logic [7:0]  cov;
      logic [23:0] color;
      logic        in_image;
      logic        last;
      logic        done;
   } pixel_write_type;

   localparam bit CMD_STEP = 1'b1;
   localparam int LIMIT_CYCLES = 400000;
   localparam int IDLE_CYCLES = 80;
   localparam int HOLD_CYCLES = 300;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [DIM_REG_W-1:0]  csr_data;

   antialiased_line_rasterizer i_dut (.*);

   pixel_write_type pending_writes[$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           hold_request = 0;

   // shadow of the line state
   longint img_w, img_h;
   bit     steep;
   longint cur_col, end_col, cross_pos, slope;
   longint held_op, held_color;
   bit     active;

   raster_item_type directed_rows[20] = '{
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, 21'sd512, 21'sd768, 21'sd1536, 21'sd768, 8'd255, 24'hFFFFFF},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, 21'sd1408, 21'sd320, 21'sd1088, 21'sd1984, 8'd128, 24'h123456},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, 21'sd2688, 21'sd2688, 21'sd2688, 21'sd2688, 8'd255, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, 21'sd1048575, -21'sd1048576, -21'sd1048576, 21'sd1048575, 8'd0,
        24'hAAAAAA},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, -21'sd845, -21'sd845, -21'sd742, -21'sd700, 8'd255, 24'h555555},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, 21'sd1048575, 21'sd1048575, -21'sd1048576, -21'sd1048576, 8'd255,
        24'hFFFFFF},
      '{CMD_STEP, 21'sd0, 21'sd0, 21'sd0, 21'sd0, 8'd0, 24'h0},
      '{CMD_START, 21'sd0, 21'sd0, 21'sd5000, -21'sd700, 8'd77, 24'h00FF00}
   };

   function automatic longint wrap_bits(longint v, int bits);
      return (v <<< (64 - bits)) >>> (64 - bits);
   endfunction

   function automatic void push_write(longint major, longint minor, longint cov, longint color,
                                      bit last, bit done);
      pixel_write_type w;
      longint px, py, wl, hl;
      px = wrap_bits(steep ? minor : major, 14);
      py = wrap_bits(steep ? major : minor, 14);
      wl = (img_w > 4096) ? 4096 : img_w;
      hl = (img_h > 4096) ? 4096 : img_h;
      w.px = px[13:0];
      w.py = py[13:0];
      w.cov = cov[7:0];
      w.color = color[23:0];
      w.in_image = (px >= 0 && py >= 0 && px < wl && py < hl);
      w.last = last;
      w.done = done;
      pending_writes.push_back(w);
   endfunction

   function automatic void endpoint_pair(longint xc, longint yc, bit first, bit last,
                                         bit done, output longint col, output longint yend);
      longint fr, gap, yi, f;
      col = (xc + 128) >>> 8;
      yend = (yc * 65536 + slope * (col * 256 - xc)) >>> 8;
      fr = (xc + 128) & 255;
      gap = first ? 256 - fr : fr;
      yi = yend >>> 16;
      f = yend & 65535;
      push_write(col, yi, ((65536 - f) * gap * held_op) >>> 24, held_color, 1'b0, done);
      push_write(col, yi + 1, (f * gap * held_op) >>> 24, held_color, last, done);
   endfunction

   function automatic void predict_line(raster_item_type it);
      longint x0, y0, x1, y1, t, dx, dy, c1, c2, ye1, ye2, yi, f, col;
      bit done;
      if (it.cmd == CMD_START) begin
         x0 = it.sx; y0 = it.sy; x1 = it.ex; y1 = it.ey;
         held_op = it.op;
         held_color = it.color;
         dx = (x1 > x0) ? x1 - x0 : x0 - x1;
         dy = (y1 > y0) ? y1 - y0 : y0 - y1;
         steep = dy > dx;
         if (steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
         end
         if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
         end
         dx = x1 - x0;
         dy = y1 - y0;
         slope = (dx == 0) ? 65536 : (dy * 65536) / dx;
         // precompute end column to know done before emitting
         c1 = (x0 + 128) >>> 8;
         c2 = (x1 + 128) >>> 8;
         cur_col = wrap_bits(c1 + 1, 14);
         end_col = wrap_bits(c2, 14);
         active = cur_col < end_col;
         done = !active;
         endpoint_pair(x0, y0, 1'b1, 1'b0, done, c1, ye1);
         endpoint_pair(x1, y1, 1'b0, 1'b1, done, c2, ye2);
         cross_pos = wrap_bits(ye1 + slope, 30);
      end else if (active) begin
         col = cur_col;
         yi = cross_pos >>> 16;
         f = cross_pos & 65535;
         cross_pos = wrap_bits(cross_pos + slope, 30);
         cur_col = wrap_bits(cur_col + 1, 14);
         active = cur_col < end_col;
         push_write(col, yi, ((65536 - f) * held_op) >>> 16, held_color, 1'b0, !active);
         push_write(col, yi + 1, (f * held_op) >>> 16, held_color, 1'b1, !active);
      end
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // compare each transfer against the oldest expected write
   always @(posedge clock) begin
      pixel_write_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected pixel write %h", rsp_tdata);
            error_count++;
         end else begin
            e = pending_writes.pop_front();
            if (rsp_tdata[13:0] !== e.px) begin
               $error("pixel_x exp %h got %h", e.px, rsp_tdata[13:0]); error_count++;
            end
            if (rsp_tdata[27:14] !== e.py) begin
               $error("pixel_y exp %h got %h", e.py, rsp_tdata[27:14]); error_count++;
            end
            if (rsp_tdata[35:28] !== e.cov) begin
               $error("coverage exp %h got %h", e.cov, rsp_tdata[35:28]); error_count++;
            end
            if (rsp_tdata[59:36] !== e.color) begin
               $error("pixel_color exp %h got %h", e.color, rsp_tdata[59:36]); error_count++;
            end
            if (rsp_tuser[0] !== e.in_image) begin
               $error("inside_res exp %b got %b", e.in_image, rsp_tuser[0]); error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last exp %b got %b", e.last, rsp_tlast); error_count++;
            end
            if (rsp_tuser[1] !== e.done) begin
               $error("done_res exp %b got %b", e.done, rsp_tuser[1]); error_count++;
            end
         end
      end
   end

   // receiver
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 0;
         end else begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(9);
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(raster_item_type it);
      int gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(9);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= it.cmd;
      req_tdata <= {4'b0, it.color, it.op, it.ey, it.ex, it.sy, it.sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_line(it);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) img_w = val;
      else if (idx == CSR_IMAGE_HEIGHT) img_h = val;
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   function automatic logic signed [20:0] rand_coord(int mode);
      if (mode == 0) return 21'($urandom_range(6400)) - 21'sd512;
      if (mode == 1) return 21'($urandom);
      return $urandom_range(1) ? 21'sd1048575 : -21'sd1048576;
   endfunction

   task automatic random_phase(int n_items);
      raster_item_type it;
      int sent, steps, mode;
      sent = 0;
      while (sent < n_items) begin
         mode = ($urandom_range(9) < 7) ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
         it.cmd = ($urandom_range(9) == 0) ? CMD_STEP : CMD_START;
         it.sx = rand_coord(mode);
         it.sy = rand_coord(mode);
         it.ex = rand_coord(mode);
         it.ey = rand_coord(mode);
         it.op = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0) : 8'($urandom);
         it.color = 24'($urandom);
         send_item(it);
         sent++;
         steps = $urandom_range(14);
         repeat (steps) begin
            it.cmd = CMD_STEP;
            it.sx = 21'($urandom);
            it.color = 24'($urandom);
            send_item(it);
            sent++;
         end
      end
   endtask

   initial begin
      img_w = WIDTH_RESET;
      img_h = HEIGHT_RESET;
      steep = 0; cur_col = 0; end_col = 0; cross_pos = 0; slope = 0;
      held_op = 0; held_color = 0; active = 0;
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_idle();

      write_csr(CSR_IMAGE_WIDTH, 13'd1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd1);
      write_csr(2'd3, 13'd5);
      hold_request = 1;
      random_phase(30);
      wait_idle();

      write_csr(CSR_IMAGE_WIDTH, 13'd4096);
      write_csr(CSR_IMAGE_HEIGHT, 13'd8191);
      random_phase(30);
      wait_idle();

      write_csr(CSR_IMAGE_WIDTH, 13'($urandom_range(4096, 1)));
      write_csr(CSR_IMAGE_HEIGHT, 13'($urandom_range(4096, 1)));
      write_csr(2'd2, 13'd0);
      random_phase(30);
      wait_idle();

      if (error_count == 0 && pending_writes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
